>>> rtl/core/elliptic_curve_point_counter_top_assert.svh
// Assertion macros for the point counter.
`ifndef ELLIPTIC_CURVE_POINT_COUNTER_TOP_ASSERT_SVH
`define ELLIPTIC_CURVE_POINT_COUNTER_TOP_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define ECPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define ECPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/ecpc_pkg.sv
package ecpc_pkg;
    // Width of the coefficients and the modulus inside the datapath.
    localparam int MOD_BITS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X2,
        ST_X3,
        ST_AX,
        ST_RHS,
        ST_PSETUP,
        ST_PMUL,
        ST_PSQR,
        ST_ACCUM,
        ST_NEXT,
        ST_DONE
    } t_state;
endpackage

>>> rtl/core/ecpc_modmul.sv
// Shift-and-add modular multiplier: one bit of the multiplier per cycle.
// Operands must already be reduced below the modulus.
module ecpc_modmul #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_op_a,
    input  logic [W-1:0] i_op_b,
    input  logic [W-1:0] i_mod,
    output logic         o_done,
    output logic [W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_mb;
    logic [W-1:0] r_ma;
    logic [W-1:0] r_mod;
    logic [CW-1:0] r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [W:0]   dbl;
    logic [W:0]   dbl_r;
    logic [W:0]   sum;

    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, r_mod}) ? dbl - {1'b0, r_mod} : dbl;
        sum   = dbl_r + {1'b0, r_ma};
        if (r_mb[W-1]) begin
            n_acc = (sum >= {1'b0, r_mod}) ? W'(sum - {1'b0, r_mod}) : W'(sum);
        end else begin
            n_acc = W'(dbl_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_ma  <= i_op_a;
            r_mb  <= i_op_b;
            r_mod <= i_mod;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mb  <= {r_mb[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> rtl/core/elliptic_curve_point_counter_top.sv
// Elliptic-curve point counter.
// The slave channel (s_axis_*) takes one query word holding a, b and the
// modulus p. The master channel (m_axis_*) returns one word holding the
// number of points on y^2 = x^3 + a*x + b over Z/pZ, including infinity,
// wrapping at 2^32.
// For every x below p the block forms the curve right-hand side and, when
// it is nonzero, raises it to (p-1)/2 by square-and-multiply. All modular
// products go through one shared shift-and-add multiplier. Two setup
// products first reduce a and b below p. A zero modulus skips setup and the
// x loop and goes from idle straight to the done state. The block accepts
// no query while one is in work. The result sits in an output register
// until the receiver takes it; a stalled receiver holds the block in its
// done state with the result stable. A new query is accepted from the cycle
// after the result is taken. Synchronous active-low reset returns the block
// to idle with no result.
module elliptic_curve_point_counter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: coef_a[15:0], coef_b[31:16], modulus[47:32].
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: point_count[31:0].
    output logic [31:0] m_axis_tdata
);
    localparam int W = ecpc_pkg::MOD_BITS;

    ecpc_pkg::t_state r_state, n_state;

    logic [W-1:0] r_a, r_b, r_p, r_x;
    logic [W-1:0] r_half;
    logic [W-1:0] r_t;       // scratch: x^2, x^3
    logic [W-1:0] r_base, r_left, r_acc;
    logic [31:0]  r_total;
    logic         r_oval;

    logic         mm_start;
    logic [W-1:0] mm_a, mm_b;
    logic         mm_done;
    logic [W-1:0] mm_prod;

    logic [W-1:0] in_a, in_b, in_p;
    logic [W:0]   s1, s2;
    logic [W-1:0] rhs;
    logic [W-1:0] b_red;

    assign in_a = W'(s_axis_tdata[15:0]);
    assign in_b = W'(s_axis_tdata[31:16]);
    assign in_p = W'(s_axis_tdata[47:32]);

    // The cube, a*x and the reduced b are all below p, so each of the two
    // additions needs at most one subtraction of p.
    assign b_red = r_b;
    always_comb begin
        s1  = {1'b0, r_t} + {1'b0, mm_prod};
        if (s1 >= {1'b0, r_p}) s1 = s1 - {1'b0, r_p};
        s2  = s1 + {1'b0, b_red};
        if (s2 >= {1'b0, r_p}) s2 = s2 - {1'b0, r_p};
        rhs = W'(s2);
    end

    ecpc_modmul #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mm_start),
        .i_op_a (mm_a),
        .i_op_b (mm_b),
        .i_mod  (r_p),
        .o_done (mm_done),
        .o_prod (mm_prod)
    );

    // Setup reduces a and then b below p before the x loop; r_red tracks
    // which of the two is being reduced.
    logic [1:0] r_red; // 2: reduce a, 1: reduce b, 0: loop

    always_comb begin
        n_state = r_state;
        case (r_state)
            ecpc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (in_p == '0) ? ecpc_pkg::ST_DONE : ecpc_pkg::ST_PSETUP;
                end
            end
            ecpc_pkg::ST_X2:   if (mm_done) n_state = ecpc_pkg::ST_X3;
            ecpc_pkg::ST_X3:   if (mm_done) n_state = ecpc_pkg::ST_AX;
            ecpc_pkg::ST_AX:   if (mm_done) n_state = ecpc_pkg::ST_RHS;
            ecpc_pkg::ST_RHS: begin
                n_state = (rhs == '0) ? ecpc_pkg::ST_NEXT : ecpc_pkg::ST_PMUL;
            end
            ecpc_pkg::ST_PSETUP: begin
                if (mm_done && r_red == 2'd1) n_state = ecpc_pkg::ST_X2;
            end
            ecpc_pkg::ST_PMUL: begin
                if (r_left == '0) n_state = ecpc_pkg::ST_ACCUM;
                else if (!r_left[0] || mm_done) n_state = ecpc_pkg::ST_PSQR;
            end
            ecpc_pkg::ST_PSQR: if (mm_done) n_state = ecpc_pkg::ST_PMUL;
            ecpc_pkg::ST_ACCUM: n_state = ecpc_pkg::ST_NEXT;
            ecpc_pkg::ST_NEXT: begin
                n_state = (r_x == r_p - 1'b1) ? ecpc_pkg::ST_DONE : ecpc_pkg::ST_X2;
            end
            ecpc_pkg::ST_DONE: if (m_axis_tready) n_state = ecpc_pkg::ST_IDLE;
            default: n_state = ecpc_pkg::ST_IDLE;
        endcase
    end

    // Multiplier launch: a one-cycle start pulse on entry to each phase,
    // tracked by r_go (multiplier launched for the current phase).
    logic r_go;
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_x;
        mm_b     = r_x;
        case (r_state)
            ecpc_pkg::ST_PSETUP: begin
                // One times the raw value, scanned bit by bit, leaves the
                // value reduced mod p. One itself is zero mod a unit modulus.
                mm_start = !r_go;
                mm_a = (r_p == W'(1)) ? '0 : W'(1);
                mm_b = (r_red == 2'd2) ? r_a : r_b;
            end
            ecpc_pkg::ST_X2: begin
                mm_start = !r_go; mm_a = r_x; mm_b = r_x;
            end
            ecpc_pkg::ST_X3: begin
                mm_start = !r_go; mm_a = mm_prod; mm_b = r_x;
            end
            ecpc_pkg::ST_AX: begin
                mm_start = !r_go; mm_a = r_a; mm_b = r_x;
            end
            ecpc_pkg::ST_PMUL: begin
                mm_start = !r_go && r_left != '0 && r_left[0];
                mm_a = r_acc; mm_b = r_base;
            end
            ecpc_pkg::ST_PSQR: begin
                mm_start = !r_go; mm_a = r_base; mm_b = r_base;
            end
            default: mm_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecpc_pkg::ST_IDLE;
            r_go    <= 1'b0;
            r_oval  <= 1'b0;
            r_red   <= 2'd0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (mm_start) r_go <= 1'b1;
            if (mm_done || n_state != r_state) r_go <= 1'b0;
            if (r_state == ecpc_pkg::ST_PMUL && !r_left[0] && r_left != '0) r_go <= 1'b0;
            r_oval <= (n_state == ecpc_pkg::ST_DONE);
            case (r_state)
                ecpc_pkg::ST_IDLE: begin
                    r_total <= 32'd1;
                    r_red   <= 2'd2;
                end
                ecpc_pkg::ST_PSETUP: begin
                    if (mm_done) r_red <= r_red - 1'b1;
                end
                ecpc_pkg::ST_RHS: begin
                    if (rhs == '0) r_total <= r_total + 32'd1;
                end
                ecpc_pkg::ST_ACCUM: begin
                    // A power of p-1 stands for -1 and adds nothing.
                    if (r_acc != r_p - 1'b1)
                        r_total <= r_total + 32'd1 + 32'(r_acc);
                end
                default: r_red <= r_red;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ecpc_pkg::ST_IDLE: begin
                r_a    <= in_a;
                r_b    <= in_b;
                r_p    <= in_p;
                r_half <= (in_p - 1'b1) >> 1;
                r_x    <= '0;
            end
            ecpc_pkg::ST_PSETUP: begin
                if (mm_done) begin
                    if (r_red == 2'd2) r_a <= mm_prod;
                    else r_b <= mm_prod;
                end
            end
            ecpc_pkg::ST_X2: if (mm_done) r_t <= mm_prod;
            ecpc_pkg::ST_X3: if (mm_done) r_t <= mm_prod;
            ecpc_pkg::ST_RHS: begin
                r_base <= rhs;
                r_left <= r_half;
                r_acc  <= (r_p == W'(1)) ? '0 : W'(1);
            end
            ecpc_pkg::ST_PMUL: begin
                if (mm_done) r_acc <= mm_prod;
            end
            ecpc_pkg::ST_PSQR: begin
                if (mm_done) begin
                    r_base <= mm_prod;
                    r_left <= r_left >> 1;
                end
            end
            ecpc_pkg::ST_NEXT: r_x <= r_x + 1'b1;
            default: r_t <= r_t;
        endcase
    end

    assign s_axis_tready = (r_state == ecpc_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == ecpc_pkg::ST_DONE) && r_oval;
    assign m_axis_tdata  = r_total;

    `include "elliptic_curve_point_counter_top_assert.svh"

    `ECPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `ECPC_ASSERT_IMP(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "input ready while result pending")
    `ECPC_ASSERT_IMP(a_x_range, i_clk, i_rst_n, r_state == ecpc_pkg::ST_RHS,
        r_x < r_p && r_a < r_p && r_b < r_p, "loop operands out of range")
endmodule
